// ===== design/sgi_pkg.sv =====
// Shared types and constants for the 3D segment intersection block.
// No dependencies; every other design file but sgi_delay refers to it by scoped name.
package sgi_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int TOL_WIDTH       = 16;
    localparam int LIMB            = 32;
    localparam int QUEUE_DEPTH     = 4;

    typedef enum logic [2:0] {
        RSN_HIT        = 3'd0,
        RSN_PARALLEL   = 3'd1,
        RSN_SKEW       = 3'd2,
        RSN_OUT_FIRST  = 3'd3,
        RSN_OUT_SECOND = 3'd4
    } t_reason;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== design/sgi_if.sv =====
// Valid/ready channel interfaces for segment pairs and intersection results.
// Depends on sgi_pkg for the default coordinate width.
interface sgi_in_if #(
    parameter int W = sgi_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] a_start_x;
    logic signed [W-1:0] a_start_y;
    logic signed [W-1:0] a_start_z;
    logic signed [W-1:0] a_end_x;
    logic signed [W-1:0] a_end_y;
    logic signed [W-1:0] a_end_z;
    logic signed [W-1:0] b_start_x;
    logic signed [W-1:0] b_start_y;
    logic signed [W-1:0] b_start_z;
    logic signed [W-1:0] b_end_x;
    logic signed [W-1:0] b_end_y;
    logic signed [W-1:0] b_end_z;

    modport source (
        output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
               b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
               b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
        output ready
    );
endinterface

interface sgi_out_if #(
    parameter int W = sgi_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic                hit;
    logic [2:0]          miss_reason;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    logic signed [W-1:0] point_z;

    modport source (
        output valid, hit, miss_reason, point_x, point_y, point_z,
        input  ready
    );
    modport sink (
        input  valid, hit, miss_reason, point_x, point_y, point_z,
        output ready
    );
endinterface

// ===== design/sgi_front.sv =====
// Front end: accepts a segment pair and forms d1, d2 and w = b_start - a_start.
// Depends on sgi_pkg and sgi_in_if; feeds sgi_queue.
module sgi_front #(
    parameter int COORD_WIDTH = sgi_pkg::COORD_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    sgi_in_if.sink                   i_seg,
    input  sgi_pkg::t_q_stat         i_qstat,
    output logic                     o_push,
    output logic [3*COORD_WIDTH+9*(COORD_WIDTH+1)-1:0] o_data
);
    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 3 * W + 9 * DW;

    logic          r_vld;
    logic [PW-1:0] r_data;
    logic [PW-1:0] n_data;

    logic signed [DW-1:0] d1x, d1y, d1z, d2x, d2y, d2z, wx, wy, wz;

    always_comb begin
        d1x = DW'(i_seg.a_end_x) - DW'(i_seg.a_start_x);
        d1y = DW'(i_seg.a_end_y) - DW'(i_seg.a_start_y);
        d1z = DW'(i_seg.a_end_z) - DW'(i_seg.a_start_z);
        d2x = DW'(i_seg.b_end_x) - DW'(i_seg.b_start_x);
        d2y = DW'(i_seg.b_end_y) - DW'(i_seg.b_start_y);
        d2z = DW'(i_seg.b_end_z) - DW'(i_seg.b_start_z);
        wx  = DW'(i_seg.b_start_x) - DW'(i_seg.a_start_x);
        wy  = DW'(i_seg.b_start_y) - DW'(i_seg.a_start_y);
        wz  = DW'(i_seg.b_start_z) - DW'(i_seg.a_start_z);
        n_data = {i_seg.a_start_z, i_seg.a_start_y, i_seg.a_start_x,
                  d1z, d1y, d1x, d2z, d2y, d2x, wz, wy, wx};
    end

    // Hold the staged pair until the queue has room.
    assign o_push      = r_vld && !i_qstat.full;
    assign i_seg.ready = !r_vld || !i_qstat.full;
    assign o_data      = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_seg.ready) begin
            r_vld <= i_seg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_seg.valid && i_seg.ready) begin
            r_data <= n_data;
        end
    end
endmodule

// ===== design/sgi_queue.sv =====
// Short FIFO that decouples the front end from the arithmetic back end.
// Depends on sgi_pkg for the status struct.
module sgi_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sgi_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output sgi_pkg::t_q_stat o_stat
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CNTW-1:0]  r_cnt;

    assign o_stat.full  = (r_cnt == CNTW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end
endmodule

// ===== design/sgi_mul.sv =====
// Pipelined signed multiplier built from 33x33 limb products; registers partial products, row sums and the total.
// Depends on sgi_pkg for the limb width.
module sgi_mul #(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [WA-1:0]   i_a,
    input  logic signed [WB-1:0]   i_b,
    output logic signed [WA+WB-1:0] o_p
);
    localparam int LB  = sgi_pkg::LIMB;
    localparam int NA  = (WA + LB - 1) / LB;
    localparam int NB  = (WB + LB - 1) / LB;
    localparam int WP  = WA + WB;
    localparam int PPW = 2 * LB + 2;
    localparam int XW  = WP + PPW;

    logic signed [NA*LB-1:0] a_ext;
    logic signed [NB*LB-1:0] b_ext;
    logic signed [LB:0]      a_lb [NA];
    logic signed [LB:0]      b_lb [NB];
    logic signed [PPW-1:0]   r_pp [NA][NB];
    logic signed [XW-1:0]    n_row [NA];
    logic signed [XW-1:0]    r_row [NA];
    logic signed [XW-1:0]    n_sum;
    logic signed [XW-1:0]    r_sum;

    assign a_ext = (NA*LB)'(i_a);
    assign b_ext = (NB*LB)'(i_b);

    // Low limbs are unsigned, the top limb carries the sign.
    for (genvar i = 0; i < NA; i++) begin : g_alimb
        if (i == NA - 1) begin : g_top
            assign a_lb[i] = signed'({a_ext[NA*LB-1], a_ext[i*LB +: LB]});
        end else begin : g_low
            assign a_lb[i] = signed'({1'b0, a_ext[i*LB +: LB]});
        end
    end
    for (genvar j = 0; j < NB; j++) begin : g_blimb
        if (j == NB - 1) begin : g_top
            assign b_lb[j] = signed'({b_ext[NB*LB-1], b_ext[j*LB +: LB]});
        end else begin : g_low
            assign b_lb[j] = signed'({1'b0, b_ext[j*LB +: LB]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= a_lb[i] * b_lb[j];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (XW'(r_pp[i][j]) <<< (j * LB));
            end
        end
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            n_sum = n_sum + (r_row[i] <<< (i * LB));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row <= n_row;
            r_sum <= n_sum;
        end
    end

    assign o_p = r_sum[WP-1:0];
endmodule

// ===== design/sgi_delay.sv =====
// Enable-gated delay line that carries side data alongside the multipliers.
// No dependencies.
module sgi_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_sh [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_sh[i] <= r_sh[i-1];
            end
        end
    end

    assign o_q = r_sh[DEPTH-1];
endmodule

// ===== design/sgi_back.sv =====
// Back end: cross and dot products, classification, rounding divider, point.
// Depends on sgi_pkg, sgi_out_if, sgi_mul and sgi_delay.
module sgi_back #(
    parameter int FRAC_BITS   = sgi_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = sgi_pkg::COORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [sgi_pkg::TOL_WIDTH-1:0]     i_tol,
    input  logic [3*COORD_WIDTH+9*(COORD_WIDTH+1)-1:0] i_head,
    input  sgi_pkg::t_q_stat                  i_qstat,
    output logic                              o_pop,
    sgi_out_if.source                         o_res
);
    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;
    localparam int CW   = 2 * DW + 1;
    localparam int SW   = DW + CW + 2;
    localparam int NW   = 2 * CW + 2;
    localparam int MW   = DW + NW;
    localparam int NNW  = MW + 1;
    localparam int QW   = W + 1;
    localparam int LAST = 13 + QW;
    localparam int PW   = 3 * W + 9 * DW;
    localparam int TW   = sgi_pkg::TOL_WIDTH;
    localparam int THW  = CW + TW + FRAC_BITS;

    logic adv;
    logic r_ovld;
    logic r_vld [LAST+1];

    assign adv   = !r_ovld || o_res.ready;
    assign o_pop = adv && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= LAST; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_ovld <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= !i_qstat.empty;
            for (int i = 1; i <= LAST; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_ovld <= r_vld[LAST];
        end
    end

    // Stage 0: registered queue head
    logic [PW-1:0] r_s0;
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s0 <= i_head;
        end
    end

    logic signed [DW-1:0] w0 [3], d2_0 [3], d1_0 [3], w4 [3], d1_9 [3];
    logic signed [W-1:0]  as_l [3];
    logic [3*DW-1:0]      w4_flat, d1_9_flat;
    logic [3*W-1:0]       as_flat;

    sgi_delay #(.WIDTH(3*DW), .DEPTH(4)) u_dly_w (
        .i_clk(i_clk), .i_en(adv), .i_d(r_s0[0 +: 3*DW]), .o_q(w4_flat));
    sgi_delay #(.WIDTH(3*DW), .DEPTH(9)) u_dly_d1 (
        .i_clk(i_clk), .i_en(adv), .i_d(r_s0[6*DW +: 3*DW]), .o_q(d1_9_flat));
    sgi_delay #(.WIDTH(3*W), .DEPTH(LAST)) u_dly_as (
        .i_clk(i_clk), .i_en(adv), .i_d(r_s0[9*DW +: 3*W]), .o_q(as_flat));

    for (genvar k = 0; k < 3; k++) begin : g_unpack
        assign w0[k]   = r_s0[k*DW +: DW];
        assign d2_0[k] = r_s0[(3+k)*DW +: DW];
        assign d1_0[k] = r_s0[(6+k)*DW +: DW];
        assign w4[k]   = w4_flat[k*DW +: DW];
        assign d1_9[k] = d1_9_flat[k*DW +: DW];
        assign as_l[k] = as_flat[k*W +: W];
    end

    // First products: c = d1 x d2, xa = w x d2, xb = w x d1
    logic signed [2*DW-1:0] m_cp [3], m_cn [3], m_ap [3], m_an [3], m_bp [3], m_bn [3];
    logic signed [CW-1:0]   r_c [3], r_xa [3], r_xb [3];

    for (genvar k = 0; k < 3; k++) begin : g_m1
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;
        sgi_mul #(.WA(DW), .WB(DW)) u_cp (.i_clk(i_clk), .i_en(adv),
            .i_a(d1_0[K1]), .i_b(d2_0[K2]), .o_p(m_cp[k]));
        sgi_mul #(.WA(DW), .WB(DW)) u_cn (.i_clk(i_clk), .i_en(adv),
            .i_a(d1_0[K2]), .i_b(d2_0[K1]), .o_p(m_cn[k]));
        sgi_mul #(.WA(DW), .WB(DW)) u_ap (.i_clk(i_clk), .i_en(adv),
            .i_a(w0[K1]), .i_b(d2_0[K2]), .o_p(m_ap[k]));
        sgi_mul #(.WA(DW), .WB(DW)) u_an (.i_clk(i_clk), .i_en(adv),
            .i_a(w0[K2]), .i_b(d2_0[K1]), .o_p(m_an[k]));
        sgi_mul #(.WA(DW), .WB(DW)) u_bp (.i_clk(i_clk), .i_en(adv),
            .i_a(w0[K1]), .i_b(d1_0[K2]), .o_p(m_bp[k]));
        sgi_mul #(.WA(DW), .WB(DW)) u_bn (.i_clk(i_clk), .i_en(adv),
            .i_a(w0[K2]), .i_b(d1_0[K1]), .o_p(m_bn[k]));
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_c[k]  <= CW'(m_cp[k]) - CW'(m_cn[k]);
                r_xa[k] <= CW'(m_ap[k]) - CW'(m_an[k]);
                r_xb[k] <= CW'(m_bp[k]) - CW'(m_bn[k]);
            end
        end
    end

    // Parallel test on |c_i| against the tolerance scaled to raw product units
    logic [CW-1:0]  c_mag [3];
    logic [THW-1:0] thr;
    logic           par_n, par_d;

    always_comb begin
        thr   = THW'(i_tol) << FRAC_BITS;
        par_n = 1'b1;
        for (int k = 0; k < 3; k++) begin
            c_mag[k] = r_c[k][CW-1] ? CW'(-r_c[k]) : CW'(r_c[k]);
            if (THW'(c_mag[k]) > thr) begin
                par_n = 1'b0;
            end
        end
    end

    sgi_delay #(.WIDTH(1), .DEPTH(3)) u_dly_par (
        .i_clk(i_clk), .i_en(adv), .i_d(par_n), .o_q(par_d));

    // Second products: w.c, c.c, xa.c, xb.c
    logic signed [DW+CW-1:0] m_wc [3];
    logic signed [2*CW-1:0]  m_cc [3], m_tc [3], m_sc [3];

    for (genvar k = 0; k < 3; k++) begin : g_m2
        sgi_mul #(.WA(DW), .WB(CW)) u_wc (.i_clk(i_clk), .i_en(adv),
            .i_a(w4[k]), .i_b(r_c[k]), .o_p(m_wc[k]));
        sgi_mul #(.WA(CW), .WB(CW)) u_cc (.i_clk(i_clk), .i_en(adv),
            .i_a(r_c[k]), .i_b(r_c[k]), .o_p(m_cc[k]));
        sgi_mul #(.WA(CW), .WB(CW)) u_tc (.i_clk(i_clk), .i_en(adv),
            .i_a(r_xa[k]), .i_b(r_c[k]), .o_p(m_tc[k]));
        sgi_mul #(.WA(CW), .WB(CW)) u_sc (.i_clk(i_clk), .i_en(adv),
            .i_a(r_xb[k]), .i_b(r_c[k]), .o_p(m_sc[k]));
    end

    logic signed [SW-1:0] r_wc;
    logic signed [NW-1:0] r_den, r_tn, r_sn;
    logic                 r_par;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_wc  <= SW'(m_wc[0]) + SW'(m_wc[1]) + SW'(m_wc[2]);
            r_den <= NW'(m_cc[0]) + NW'(m_cc[1]) + NW'(m_cc[2]);
            r_tn  <= NW'(m_tc[0]) + NW'(m_tc[1]) + NW'(m_tc[2]);
            r_sn  <= NW'(m_sc[0]) + NW'(m_sc[1]) + NW'(m_sc[2]);
            r_par <= par_d;
        end
    end

    // Classify: parallel, then skew, then t outside, then s outside
    sgi_pkg::t_reason     n_rsn, r_rsn_c;
    logic signed [NW-1:0] r_den_c, r_tn_c;

    always_comb begin
        if (r_par) begin
            n_rsn = sgi_pkg::RSN_PARALLEL;
        end else if (r_wc != '0) begin
            n_rsn = sgi_pkg::RSN_SKEW;
        end else if (r_tn[NW-1] || (r_den < r_tn)) begin
            n_rsn = sgi_pkg::RSN_OUT_FIRST;
        end else if (r_sn[NW-1] || (r_den < r_sn)) begin
            n_rsn = sgi_pkg::RSN_OUT_SECOND;
        end else begin
            n_rsn = sgi_pkg::RSN_HIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rsn_c <= n_rsn;
            r_den_c <= r_den;
            r_tn_c  <= r_tn;
        end
    end

    // Third products: d1_i * tn
    logic signed [MW-1:0] m_num [3];
    for (genvar k = 0; k < 3; k++) begin : g_m3
        sgi_mul #(.WA(DW), .WB(NW)) u_num (.i_clk(i_clk), .i_en(adv),
            .i_a(d1_9[k]), .i_b(r_tn_c), .o_p(m_num[k]));
    end

    logic [NW+2:0]        side3;
    logic signed [NW-1:0] den3;
    sgi_pkg::t_reason     rsn3;

    sgi_delay #(.WIDTH(NW+3), .DEPTH(3)) u_dly_side (
        .i_clk(i_clk), .i_en(adv), .i_d({r_rsn_c, r_den_c}), .o_q(side3));
    assign den3 = side3[NW-1:0];
    assign rsn3 = sgi_pkg::t_reason'(side3[NW+2:NW]);

    // Rounded quotient setup: q = (2|num| + den) / (2 den)
    logic [MW-1:0]    num_mag [3];
    logic [NNW-1:0]   r_n_d [3];
    logic [NNW-1:0]   r_dv_d;
    logic [2:0]       r_neg_d;
    sgi_pkg::t_reason r_rsn_d;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            num_mag[k] = m_num[k][MW-1] ? MW'(-m_num[k]) : MW'(m_num[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_n_d[k]   <= (NNW'(num_mag[k]) << 1) + NNW'(unsigned'(den3));
                r_neg_d[k] <= m_num[k][MW-1];
            end
            r_dv_d  <= NNW'(unsigned'(den3)) << 1;
            r_rsn_d <= rsn3;
        end
    end

    // Restoring divider, one quotient bit per stage, most significant first
    logic [NNW-1:0]   r_dn  [QW][3];
    logic [QW-1:0]    r_dq  [QW][3];
    logic [NNW-1:0]   r_dd  [QW];
    logic [2:0]       r_dneg [QW];
    sgi_pkg::t_reason r_drsn [QW];

    for (genvar s = 0; s < QW; s++) begin : g_div
        logic [NNW-1:0]   n_in [3];
        logic [QW-1:0]    q_in [3];
        logic [NNW-1:0]   d_in;
        logic [2:0]       neg_in;
        sgi_pkg::t_reason rsn_in;
        logic [NNW-1:0]   sh;
        logic [NNW-1:0]   n_out [3];
        logic [QW-1:0]    q_out [3];

        if (s == 0) begin : g_first
            assign n_in   = r_n_d;
            assign q_in   = '{default: '0};
            assign d_in   = r_dv_d;
            assign neg_in = r_neg_d;
            assign rsn_in = r_rsn_d;
        end else begin : g_next
            assign n_in   = r_dn[s-1];
            assign q_in   = r_dq[s-1];
            assign d_in   = r_dd[s-1];
            assign neg_in = r_dneg[s-1];
            assign rsn_in = r_drsn[s-1];
        end

        always_comb begin
            sh = d_in << (QW - 1 - s);
            for (int k = 0; k < 3; k++) begin
                if (n_in[k] >= sh) begin
                    n_out[k] = n_in[k] - sh;
                    q_out[k] = q_in[k] | (QW'(1) << (QW - 1 - s));
                end else begin
                    n_out[k] = n_in[k];
                    q_out[k] = q_in[k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dn[s]   <= n_out;
                r_dq[s]   <= q_out;
                r_dd[s]   <= d_in;
                r_dneg[s] <= neg_in;
                r_drsn[s] <= rsn_in;
            end
        end
    end

    // Point = a_start + signed quotient; zero on a miss
    logic signed [W+1:0] q_s [3];
    logic signed [W+1:0] p_s [3];
    logic signed [W-1:0] n_pt [3];
    logic                n_hit;

    always_comb begin
        n_hit = (r_drsn[QW-1] == sgi_pkg::RSN_HIT);
        for (int k = 0; k < 3; k++) begin
            q_s[k] = r_dneg[QW-1][k] ? -signed'((W+2)'(r_dq[QW-1][k]))
                                     :  signed'((W+2)'(r_dq[QW-1][k]));
            p_s[k] = (W+2)'(as_l[k]) + q_s[k];
            n_pt[k] = n_hit ? p_s[k][W-1:0] : '0;
        end
    end

    logic                r_ohit;
    sgi_pkg::t_reason    r_orsn;
    logic signed [W-1:0] r_opt [3];

    always_ff @(posedge i_clk) begin
        if (adv && r_vld[LAST]) begin
            r_ohit <= n_hit;
            r_orsn <= r_drsn[QW-1];
            r_opt  <= n_pt;
        end
    end

    assign o_res.valid       = r_ovld;
    assign o_res.hit         = r_ohit;
    assign o_res.miss_reason = r_orsn;
    assign o_res.point_x     = r_opt[0];
    assign o_res.point_y     = r_opt[1];
    assign o_res.point_z     = r_opt[2];
endmodule

// ===== design/segment_intersect_3d.sv =====
// Intersection of two 3D segments in signed fixed point. One segment pair enters
// per clock and one result leaves per clock in steady state while the output is
// not stalled. Most of the pipeline lies in the divider that rounds the point,
// which resolves one quotient bit per pipeline stage. The front end forms the
// difference vectors and parks them in a four-entry queue; the back end runs
// three rounds of pipelined limb multipliers (cross products, dot products,
// d1 * t numerator), classifies the pair, and divides. A result is a miss with
// a reason code (parallel, skew, outside the first segment, outside the second)
// and a zero point, or a hit with the point rounded to nearest, ties away from
// zero. The parallel tolerance is compared against each cross product component;
// write it only while no transaction is in flight. Both channels stall
// independently: backpressure on the output holds the whole back end, and the
// queue keeps the input side taking pairs until it fills.
// Depends on sgi_pkg, sgi_if, sgi_front, sgi_queue and sgi_back.
module segment_intersect_3d #(
    parameter int FRAC_BITS   = sgi_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = sgi_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sgi_pkg::TOL_WIDTH-1:0] i_cfg_wdata,
    sgi_in_if.sink                        i_seg,
    sgi_out_if.source                     o_res
);
    localparam int W  = COORD_WIDTH;
    localparam int PW = 3 * W + 9 * (W + 1);

    // Tolerance register: hold its value between writes
    logic [sgi_pkg::TOL_WIDTH-1:0] r_tol;
    logic [sgi_pkg::TOL_WIDTH-1:0] n_tol;

    assign n_tol = i_cfg_we ? i_cfg_wdata : r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else begin
            r_tol <= n_tol;
        end
    end

    logic             push;
    logic             pop;
    logic [PW-1:0]    front_data;
    logic [PW-1:0]    head;
    sgi_pkg::t_q_stat qstat;

    // Accept pairs and form the difference vectors
    sgi_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (i_seg),
        .i_qstat (qstat),
        .o_push  (push),
        .o_data  (front_data)
    );

    // Decouple front and back so each side stalls on its own
    sgi_queue #(.WIDTH(PW), .DEPTH(sgi_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_data),
        .i_pop   (pop),
        .o_data  (head),
        .o_stat  (qstat)
    );

    // Advance the arithmetic pipeline and drive the result transaction
    sgi_back #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tol   (r_tol),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_res   (o_res)
    );
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for segment_intersect_3d: random and constructed segment pairs.
// Depends on sgi_pkg, the sgi_in_if/sgi_out_if interfaces and the design files.
module tb_top;

    localparam int CW         = sgi_pkg::COORD_WIDTH_DEF;
    localparam int FB         = sgi_pkg::FRAC_BITS_DEF;
    localparam int DRAIN_WAIT = 80;   // comfortably above the pipeline latency

    typedef logic signed [255:0] t_wide;
    typedef t_wide t_vec3 [3];

    // One segment pair, ordered as the twelve input fields.
    typedef struct {
        logic signed [CW-1:0] c [12];
    } t_seg_pair;

    typedef struct {
        logic                 hit;
        sgi_pkg::t_reason     reason;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] pz;
    } t_isect;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [sgi_pkg::TOL_WIDTH-1:0] i_cfg_wdata = '0;

    sgi_in_if  #(.W(CW)) seg_if ();
    sgi_out_if #(.W(CW)) res_if ();

    segment_intersect_3d u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_seg      (seg_if),
        .o_res      (res_if)
    );

    always #5 i_clk = ~i_clk;

    t_seg_pair      pending_pairs [$];
    t_isect         expected_isects [$];
    logic [15:0]    tolerance = '0;
    int             error_count = 0;
    int             accepted_pairs = 0;
    t_seg_pair      driven_pair;
    int             burst_left = 0;
    int             gap_left = 0;
    int             hold_left = 0;
    logic           hold_done = 1'b0;
    int             stall_phase = 0;
    int             stall_mode = 0;

    // ---------------------------------------------------------------- prediction
    function automatic void cross3(input t_vec3 a, input t_vec3 b, output t_vec3 r);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic t_wide dot3(input t_vec3 a, input t_vec3 b);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic t_wide mag(input t_wide v);
        return (v < 0) ? -v : v;
    endfunction

    // Classify the pair and, on a hit, round a_start + d1*t to the nearest raw unit.
    function automatic t_isect predict_intersection(input t_seg_pair p, input logic [15:0] tol);
        t_vec3  as, d1, d2, w, c, x;
        t_wide  thr, den, tn, sn, num, m, q, pt;
        logic   par;
        t_isect r;
        par = 1'b1;
        for (int i = 0; i < 3; i++) begin
            as[i] = t_wide'(p.c[i]);
            d1[i] = t_wide'(p.c[3 + i]) - as[i];
            d2[i] = t_wide'(p.c[9 + i]) - t_wide'(p.c[6 + i]);
            w[i]  = t_wide'(p.c[6 + i]) - as[i];
        end
        r.hit = 1'b0;
        r.reason = sgi_pkg::RSN_HIT;
        r.px = '0;
        r.py = '0;
        r.pz = '0;
        cross3(d1, d2, c);
        thr = t_wide'({tol, {FB{1'b0}}});
        for (int i = 0; i < 3; i++) begin
            if (mag(c[i]) > thr) par = 1'b0;
        end
        if (par) begin
            r.reason = sgi_pkg::RSN_PARALLEL;
        end else if (dot3(w, c) != 0) begin
            r.reason = sgi_pkg::RSN_SKEW;
        end else begin
            den = dot3(c, c);
            cross3(w, d2, x);
            tn = dot3(x, c);
            cross3(w, d1, x);
            sn = dot3(x, c);
            if (tn < 0 || tn > den) begin
                r.reason = sgi_pkg::RSN_OUT_FIRST;
            end else if (sn < 0 || sn > den) begin
                r.reason = sgi_pkg::RSN_OUT_SECOND;
            end else begin
                r.hit = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    num = d1[i] * tn;
                    m = mag(num);
                    q = (2 * m + den) / (2 * den);
                    if (num < 0) q = -q;
                    pt = as[i] + q;
                    if (i == 0) r.px = pt[CW-1:0];
                    else if (i == 1) r.py = pt[CW-1:0];
                    else r.pz = pt[CW-1:0];
                end
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus
    function automatic int rnd_signed(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_seg_pair noise_pair();
        t_seg_pair p;
        for (int i = 0; i < 12; i++) p.c[i] = $urandom;
        return p;
    endfunction

    // Two segments through a common point; kind picks a hit, a miss on either
    // segment, a skew pair (one coordinate nudged) or a parallel pair.
    function automatic t_seg_pair crossing_pair(input int kind);
        t_seg_pair p;
        int pt [3], e1 [3], e2 [3];
        int p1, q1, p2, q2, off;
        p1 = $urandom_range(0, 8);
        q1 = $urandom_range(1, 8);
        p2 = $urandom_range(0, 8);
        q2 = $urandom_range(1, 8);
        if ($urandom_range(0, 5) == 0) begin
            p1 = 0;                     // meet exactly at an endpoint
        end
        if ($urandom_range(0, 5) == 0) begin
            q2 = 0;
            p2 = $urandom_range(1, 8);
        end
        if (kind == 1) begin
            p1 = -int'($urandom_range(1, 4));
            q1 = $urandom_range(5, 8);
        end
        if (kind == 2) begin
            p2 = -int'($urandom_range(1, 4));
            q2 = $urandom_range(5, 8);
        end
        for (int i = 0; i < 3; i++) begin
            pt[i] = rnd_signed(1 << 24);
            e1[i] = rnd_signed(1 << 12);
            e2[i] = rnd_signed(1 << 12);
        end
        for (int i = 0; i < 3; i++) begin
            p.c[i]     = pt[i] - e1[i] * p1;
            p.c[3 + i] = pt[i] + e1[i] * q1;
            if (kind == 4) begin
                off = rnd_signed(1 << 16);
                p.c[6 + i] = p.c[i] + off;
                p.c[9 + i] = p.c[i] + off + e1[i] * int'($urandom_range(1, 4));
            end else begin
                p.c[6 + i] = pt[i] - e2[i] * p2;
                p.c[9 + i] = pt[i] + e2[i] * q2;
            end
        end
        if (kind == 3) p.c[6 + $urandom_range(0, 2)] += 1;
        return p;
    endfunction

    function automatic t_seg_pair fill_pair(input logic signed [CW-1:0] v);
        t_seg_pair p;
        for (int i = 0; i < 12; i++) p.c[i] = v;
        return p;
    endfunction

    task automatic queue_directed();
        t_seg_pair p;
        pending_pairs.push_back(fill_pair({1'b0, {(CW-1){1'b1}}}));
        pending_pairs.push_back(fill_pair({1'b1, {(CW-1){1'b0}}}));
        pending_pairs.push_back(fill_pair('0));
        // full-scale directions, both signs
        p = fill_pair({1'b1, {(CW-1){1'b0}}});
        p.c[3] = {1'b0, {(CW-1){1'b1}}};
        p.c[10] = {1'b0, {(CW-1){1'b1}}};
        p.c[11] = {1'b0, {(CW-1){1'b1}}};
        pending_pairs.push_back(p);
        p = fill_pair({1'b0, {(CW-1){1'b1}}});
        p.c[4] = {1'b1, {(CW-1){1'b0}}};
        p.c[9] = {1'b1, {(CW-1){1'b0}}};
        p.c[8] = {1'b1, {(CW-1){1'b0}}};
        pending_pairs.push_back(p);
        // exact endpoint contact: t = 0 and s = 0, then t = 1 at the middle of b
        p = fill_pair('0);
        p.c[3] = 32'sh0001_0000;
        p.c[9] = 32'sh0000_0000;
        p.c[10] = 32'sh0001_0000;
        pending_pairs.push_back(p);
        p.c[6] = 32'sh0001_0000;
        p.c[9] = 32'sh0001_0000;
        p.c[7] = 32'shffff_0000;
        pending_pairs.push_back(p);
        // rounding ties: d1 = 1 raw unit, crossing at its middle
        p = fill_pair('0);
        p.c[3] = 32'sh1;
        p.c[4] = 32'sh1;
        p.c[6] = 32'sh1;
        p.c[9] = 32'sh0;
        p.c[10] = 32'sh1;
        pending_pairs.push_back(p);
        p.c[3] = -32'sh1;
        p.c[4] = -32'sh1;
        p.c[6] = -32'sh1;
        p.c[10] = -32'sh1;
        pending_pairs.push_back(p);
        for (int k = 0; k < 5; k++) pending_pairs.push_back(crossing_pair(k));
        for (int k = 0; k < 4; k++) pending_pairs.push_back(noise_pair());
    endtask

    task automatic queue_random(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) pending_pairs.push_back(crossing_pair(0));
            else if (pick < 50) pending_pairs.push_back(crossing_pair(1));
            else if (pick < 60) pending_pairs.push_back(crossing_pair(2));
            else if (pick < 70) pending_pairs.push_back(crossing_pair(3));
            else if (pick < 80) pending_pairs.push_back(crossing_pair(4));
            else pending_pairs.push_back(noise_pair());
        end
    endtask

    // Wait until every queued pair is accepted and every result has come back.
    task automatic drain();
        while (pending_pairs.size() != 0 || seg_if.valid || expected_isects.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        tolerance <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------- driver
    // Offer pairs in bursts with random gaps; predict each transaction as it is taken.
    always @(posedge i_clk) begin
        if (seg_if.valid && seg_if.ready) begin
            expected_isects.push_back(predict_intersection(driven_pair, tolerance));
            accepted_pairs <= accepted_pairs + 1;
        end
        if (!seg_if.valid || seg_if.ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                seg_if.valid <= 1'b0;
            end else if (pending_pairs.size() != 0) begin
                driven_pair = pending_pairs.pop_front();
                seg_if.valid     <= 1'b1;
                seg_if.a_start_x <= driven_pair.c[0];
                seg_if.a_start_y <= driven_pair.c[1];
                seg_if.a_start_z <= driven_pair.c[2];
                seg_if.a_end_x   <= driven_pair.c[3];
                seg_if.a_end_y   <= driven_pair.c[4];
                seg_if.a_end_z   <= driven_pair.c[5];
                seg_if.b_start_x <= driven_pair.c[6];
                seg_if.b_start_y <= driven_pair.c[7];
                seg_if.b_start_z <= driven_pair.c[8];
                seg_if.b_end_x   <= driven_pair.c[9];
                seg_if.b_end_y   <= driven_pair.c[10];
                seg_if.b_end_z   <= driven_pair.c[11];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                seg_if.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- receiver
    // Hold off once for a long stretch after some traffic so the queue fills.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_pairs >= 120) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
    end

    // Stall pattern: pick a random mode from free flow, light and heavy stalls at each phase boundary.
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 64 == 63) stall_mode <= $urandom_range(0, 2);
        if (hold_left > 0) res_if.ready <= 1'b0;
        else if (stall_mode == 0) res_if.ready <= 1'b1;
        else if (stall_mode == 1) res_if.ready <= ($urandom_range(0, 9) != 0);
        else res_if.ready <= ($urandom_range(0, 1) != 0);
    end

    // ---------------------------------------------------------------- monitor
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_isect want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_isects.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_isects.pop_front();
                if (res_if.hit !== want.hit) report_mismatch("hit", res_if.hit, want.hit);
                if (res_if.miss_reason !== want.reason)
                    report_mismatch("miss_reason", res_if.miss_reason, want.reason);
                if (res_if.point_x !== want.px) report_mismatch("point_x", res_if.point_x, want.px);
                if (res_if.point_y !== want.py) report_mismatch("point_y", res_if.point_y, want.py);
                if (res_if.point_z !== want.pz) report_mismatch("point_z", res_if.point_z, want.pz);
            end
        end
    end

    // ---------------------------------------------------------------- sequence
    initial begin
        seg_if.valid = 1'b0;
        res_if.ready = 1'b0;
        for (int i = 0; i < 12; i++) driven_pair.c[i] = '0;
        seg_if.a_start_x = '0; seg_if.a_start_y = '0; seg_if.a_start_z = '0;
        seg_if.a_end_x = '0;   seg_if.a_end_y = '0;   seg_if.a_end_z = '0;
        seg_if.b_start_x = '0; seg_if.b_start_y = '0; seg_if.b_start_z = '0;
        seg_if.b_end_x = '0;   seg_if.b_end_y = '0;   seg_if.b_end_z = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset tolerance of zero first
        queue_directed();
        queue_random(150);
        drain();

        write_tolerance(16'hffff);
        queue_directed();
        queue_random(100);
        drain();

        write_tolerance(16'h0000);
        queue_random(100);
        drain();

        write_tolerance(16'(1 << $urandom_range(0, 15)));
        queue_random(100);
        drain();

        write_tolerance(16'($urandom));
        queue_random(50);
        drain();

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
